@@ rtl/rqp_pkg.sv @@
// ----------------------------------------------------------------------------
// Random queen placer package
// Shared constants, codes and types of the random queen placer.
// ----------------------------------------------------------------------------
`default_nettype none
package rqp_pkg;

    localparam int MAX_QUEENS = 32;
    localparam int DIAG_COUNT = 2 * MAX_QUEENS - 1;
    localparam int IDX_W      = $clog2(MAX_QUEENS);
    localparam int CNT_W      = $clog2(MAX_QUEENS + 1);
    localparam int DIAG_W     = $clog2(DIAG_COUNT);
    localparam int RAND_W     = 32;
    localparam int STEP_W     = $clog2(RAND_W);
    localparam int SIZE_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_PLACE   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_PLACED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RESTARTED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP,
        S_DIV,
        S_PICK_A,
        S_PICK_B,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             a_en;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] a_data;
        logic             b_en;
        logic [IDX_W-1:0] b_addr;
        logic [IDX_W-1:0] b_data;
    } cell_wr_t;

endpackage
`default_nettype wire

@@ rtl/rqp_if.sv @@
// ----------------------------------------------------------------------------
// Random queen placer channels
// Command and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
interface rqp_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] random_value;
    modport source (output valid, output operation, output random_value, input ready);
    modport sink (input valid, input operation, input random_value, output ready);
endinterface

interface rqp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] row;
    logic [4:0] column;
    logic       board_done;
    modport source (output valid, output status, output row, output column,
                    output board_done, input ready);
    modport sink (input valid, input status, input row, input column,
                  input board_done, output ready);
endinterface
`default_nettype wire

@@ rtl/random_queen_placer.sv @@
// ----------------------------------------------------------------------------
// Random queen placer
// Builds an N-queens board one row at a time by random column choice.
//
//   Channel   Role      Beat contents
//   cmd       sink      operation, random_value
//   res       source    status, row, column, board_done
//   cfg       write     board_size (cfg_we, cfg_wdata)
//
// A restart, or an item blocked at acceptance, goes straight to the output
// state. A place item scans the remaining columns of the cell chain and swaps
// each free column forward, then the modulo unit picks one free column and a
// final swap places it. Reset restores the identity permutation at once. A
// full result register stalls only the final write of the next result.
// ----------------------------------------------------------------------------
`default_nettype none
module random_queen_placer
    import rqp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rqp_cmd_if.sink                cmd,
    rqp_res_if.source              res,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [DIAG_COUNT-1:0] rise_reg, rise_next;
    logic [DIAG_COUNT-1:0] fall_reg, fall_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic                  alive_reg, alive_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      hold_reg, hold_next;
    logic [RAND_W-1:0]     rand_reg, rand_next;

    logic [STATUS_W-1:0]   pst_reg, pst_next;
    logic [POS_W-1:0]      prow_reg, prow_next;
    logic [POS_W-1:0]      pcol_reg, pcol_next;
    logic                  pdone_reg, pdone_next;

    logic                  ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0]   ost_reg, ost_next;
    logic [POS_W-1:0]      orow_reg, orow_next;
    logic [POS_W-1:0]      ocol_reg, ocol_next;
    logic                  odone_reg, odone_next;

    logic [CNT_W-1:0]      n;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      rd_data;
    logic [IDX_W-1:0]      chain [MAX_QUEENS+1];
    cell_wr_t              wr;
    logic                  free;
    logic [DIAG_W-1:0]     rise_idx;
    logic [DIAG_W-1:0]     fall_idx;
    logic [CNT_W-1:0]      pick;
    logic                  div_start;
    logic                  div_done;
    logic [CNT_W-1:0]      div_rem;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(size_reg) > MAX_QUEENS)
        begin
            n = CNT_W'(MAX_QUEENS);
        end
        else
        begin
            n = CNT_W'(size_reg);
        end
    end

    assign chain[0] = '0;
    assign rd_data  = chain[MAX_QUEENS];

    for (genvar i = 0; i < MAX_QUEENS; i++)
    begin : g_cell
        rqp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .rd_addr   (rd_addr),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .wr        (wr)
        );
    end

    rqp_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_reg),
        .divisor   (CNT_W'(k_reg - row_reg)),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign pick = row_reg + div_rem;

    always_comb
    begin
        rise_idx = DIAG_W'(row_reg + CNT_W'(rd_data));
        fall_idx = DIAG_W'({1'b0, row_reg} + {1'b0, n} - (CNT_W+1)'(1)
                   - (CNT_W+1)'(rd_data));
        free = (CNT_W'(rd_data) < n) && !rise_reg[rise_idx] && !fall_reg[fall_idx];
    end

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        size_next  = cfg_we ? cfg_wdata : size_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        row_next   = row_reg;
        alive_next = alive_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        hold_next  = hold_reg;
        rand_next  = rand_reg;
        pst_next   = pst_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        pdone_next = pdone_reg;
        ovalid_next = ovalid_reg && !res.ready;
        ost_next   = ost_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        odone_next = odone_reg;
        rd_addr    = IDX_W'(j_reg);
        wr         = '0;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    prow_next  = POS_W'(row_reg);
                    pcol_next  = '0;
                    pdone_next = 1'b0;
                    rand_next  = cmd.random_value;
                    if (cmd.operation == OP_RESTART)
                    begin
                        rise_next  = '0;
                        fall_next  = '0;
                        row_next   = '0;
                        alive_next = 1'b1;
                        pst_next   = STATUS_RESTARTED;
                        prow_next  = '0;
                        state_next = S_OUT;
                    end
                    else if (!alive_reg || row_reg >= n)
                    begin
                        alive_next = 1'b0;
                        pst_next   = STATUS_BLOCKED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        j_next     = row_reg;
                        k_next     = row_reg;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (j_reg >= n)
                begin
                    if (k_reg == row_reg)
                    begin
                        alive_next = 1'b0;
                        pst_next   = STATUS_BLOCKED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                    if (free)
                    begin
                        if (k_reg == j_reg)
                        begin
                            k_next = k_reg + CNT_W'(1);
                        end
                        else
                        begin
                            hold_next  = rd_data;
                            j_next     = j_reg;
                            state_next = S_SWAP;
                        end
                    end
                end
            end
            S_SWAP:
            begin
                rd_addr    = IDX_W'(k_reg);
                wr.a_en    = 1'b1;
                wr.a_addr  = IDX_W'(j_reg);
                wr.a_data  = rd_data;
                wr.b_en    = 1'b1;
                wr.b_addr  = IDX_W'(k_reg);
                wr.b_data  = hold_reg;
                k_next     = k_reg + CNT_W'(1);
                j_next     = j_reg + CNT_W'(1);
                state_next = S_SCAN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PICK_A;
                end
            end
            S_PICK_A:
            begin
                rd_addr    = IDX_W'(pick);
                hold_next  = rd_data;
                state_next = S_PICK_B;
            end
            S_PICK_B:
            begin
                rd_addr    = IDX_W'(row_reg);
                wr.a_en    = 1'b1;
                wr.a_addr  = IDX_W'(pick);
                wr.a_data  = rd_data;
                wr.b_en    = 1'b1;
                wr.b_addr  = IDX_W'(row_reg);
                wr.b_data  = hold_reg;
                rise_next[DIAG_W'(row_reg + CNT_W'(hold_reg))] = 1'b1;
                fall_next[DIAG_W'({1'b0, row_reg} + {1'b0, n} - (CNT_W+1)'(1)
                          - (CNT_W+1)'(hold_reg))] = 1'b1;
                row_next   = row_reg + CNT_W'(1);
                pst_next   = STATUS_PLACED;
                pcol_next  = POS_W'(hold_reg);
                pdone_next = (row_reg + CNT_W'(1)) == n;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = pst_reg;
                    orow_next   = prow_reg;
                    ocol_next   = pcol_reg;
                    odone_next  = pdone_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.valid      = ovalid_reg;
    assign res.status     = ost_reg;
    assign res.row        = orow_reg;
    assign res.column     = ocol_reg;
    assign res.board_done = odone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= SIZE_RESET;
            rise_reg   <= '0;
            fall_reg   <= '0;
            row_reg    <= '0;
            alive_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            j_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            row_reg    <= row_next;
            alive_reg  <= alive_next;
            ovalid_reg <= ovalid_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        rand_reg  <= rand_next;
        pst_reg   <= pst_next;
        prow_reg  <= prow_next;
        pcol_reg  <= pcol_next;
        pdone_reg <= pdone_next;
        ost_reg   <= ost_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        odone_reg <= odone_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while an item is in work");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_reg) <= MAX_QUEENS)
        else $error("next row beyond the board");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SWAP) |-> (k_reg <= j_reg && row_reg <= k_reg))
        else $error("free column pointer passed the scan pointer");

endmodule
`default_nettype wire

@@ rtl/rqp_cell.sv @@
// ----------------------------------------------------------------------------
// Random queen placer column cell
// Holds one entry of the column permutation and forwards the read chain.
// ----------------------------------------------------------------------------
`default_nettype none
module rqp_cell
    import rqp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire logic [IDX_W-1:0] chain_in,
    output logic      [IDX_W-1:0] chain_out,
    input  wire cell_wr_t         wr
);

    // The entry is stored relative to the cell's own index, so reset gives identity.
    logic [IDX_W-1:0] ofs_reg;
    logic [IDX_W-1:0] ofs_next;

    always_comb
    begin
        ofs_next = ofs_reg;
        if (wr.b_en && wr.b_addr == cell_idx)
        begin
            ofs_next = wr.b_data ^ cell_idx;
        end
        else if (wr.a_en && wr.a_addr == cell_idx)
        begin
            ofs_next = wr.a_data ^ cell_idx;
        end
    end

    assign chain_out = (rd_addr == cell_idx) ? (ofs_reg ^ cell_idx) : chain_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg <= '0;
        end
        else
        begin
            ofs_reg <= ofs_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rqp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// Random queen placer modulo unit
// Restoring remainder of the random value by the free count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rqp_mod_unit
    import rqp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAND_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   done,
    output logic      [CNT_W-1:0]  remainder
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [RAND_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        trial      = {rem_reg, shift_reg[RAND_W-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            count_next = count_reg + STEP_W'(1);
            if (count_reg == STEP_W'(RAND_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign done      = !busy_reg && !start;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

endmodule
`default_nettype wire
